### hw/rtl/utf_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 stream converter.
package utf_pkg;

  // One request on the input channel.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_t;

  // One result on the output channel.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        run_end;
    logic        stream_end;
    logic        error;
    logic [31:0] byte_total;
  } out_t;

  // Classified item passed from the front end to the byte emitter.
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the final byte
    logic            last;      // final item of the stream
    logic            err;       // unpaired surrogate at stream end
  } entry_t;

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [15:0] ASCII_MASK  = 16'hFF80;
  localparam logic [15:0] TWO_MASK    = 16'hF800;
  localparam logic [15:0] SURR_BASE   = 16'hD800;
  localparam logic [21:0] PAIR_BIAS   = 22'h002400;  // 0x10000 - 0xDC00
  localparam logic [7:0]  LEAD2       = 8'b1100_0000;
  localparam logic [7:0]  LEAD3       = 8'b1110_0000;
  localparam logic [7:0]  LEAD4       = 8'b1111_0000;
  localparam logic [7:0]  CONT        = 8'b1000_0000;
  localparam logic [5:0]  SIX_MASK    = 6'b111111;

  localparam logic [1:0]  IDX_ONE     = 2'd0;
  localparam logic [1:0]  IDX_TWO     = 2'd1;
  localparam logic [1:0]  IDX_THREE   = 2'd2;
  localparam logic [1:0]  IDX_FOUR    = 2'd3;

endpackage

### hw/rtl/utf_front.sv
// Front end: accepts code units, pairs surrogates and builds byte groups.
module utf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  utf_pkg::in_t    in_data,
  input  logic            q_full,
  output logic            q_push,
  output utf_pkg::entry_t q_data
);
  import utf_pkg::*;

  logic        pending_r, pending_nxt;
  logic [10:0] offset_r, offset_nxt;
  logic [15:0] unit;
  logic [21:0] pair_v;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign unit     = in_data.code_unit;
  assign pair_v   = {1'b0, offset_r, 10'b0} + {6'b0, unit} + PAIR_BIAS;

  always_comb begin
    pending_nxt     = pending_r;
    offset_nxt      = offset_r;
    q_push          = 1'b0;
    q_data.bytes    = '0;
    q_data.last_idx = IDX_ONE;
    q_data.last     = in_data.last_unit;
    q_data.err      = 1'b0;
    if (accept) begin
      q_push = 1'b1;
      if (pending_r) begin
        // Partner is taken as is, no low-surrogate check.
        q_data.bytes[0] = LEAD4 | {4'b0, pair_v[21:18]};
        q_data.bytes[1] = CONT | {2'b0, pair_v[17:12] & SIX_MASK};
        q_data.bytes[2] = CONT | {2'b0, pair_v[11:6] & SIX_MASK};
        q_data.bytes[3] = CONT | {2'b0, pair_v[5:0] & SIX_MASK};
        q_data.last_idx = IDX_FOUR;
        pending_nxt     = 1'b0;
        offset_nxt      = '0;
      end else if ((unit & ASCII_MASK) == '0) begin
        q_data.bytes[0] = unit[7:0];
        q_data.last_idx = IDX_ONE;
      end else if ((unit & TWO_MASK) == '0) begin
        q_data.bytes[0] = LEAD2 | {3'b0, unit[10:6]};
        q_data.bytes[1] = CONT | {2'b0, unit[5:0]};
        q_data.last_idx = IDX_TWO;
      end else if ((unit & TWO_MASK) != SURR_BASE) begin
        q_data.bytes[0] = LEAD3 | {4'b0, unit[15:12]};
        q_data.bytes[1] = CONT | {2'b0, unit[11:6]};
        q_data.bytes[2] = CONT | {2'b0, unit[5:0]};
        q_data.last_idx = IDX_THREE;
      end else if (in_data.last_unit) begin
        // Stream ends on a lone surrogate: one error result.
        q_data.err      = 1'b1;
        q_data.last_idx = IDX_ONE;
      end else begin
        // Hold the surrogate, nothing goes out yet.
        q_push      = 1'b0;
        pending_nxt = 1'b1;
        offset_nxt  = unit[10:0];
      end
      if (in_data.last_unit) begin
        pending_nxt = 1'b0;
        offset_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      offset_r  <= '0;
    end else begin
      pending_r <= pending_nxt;
      offset_r  <= offset_nxt;
    end
  end

endmodule

### hw/rtl/utf_queue.sv
// Short register queue between the front end and the byte emitter.
module utf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  utf_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output utf_pkg::entry_t pop_data
);
  import utf_pkg::*;

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/utf_back.sv
// Byte emitter: sends one byte per cycle while out_ready allows, and keeps the running byte count.
module utf_back #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  utf_pkg::entry_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output utf_pkg::out_t   out_data
);
  import utf_pkg::*;

  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_data_r, out_data_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [63:0]            count_wide;
  logic [1:0]             idx_r, idx_nxt;
  logic                   load;
  logic                   fin;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign load       = q_valid && (!out_valid_r || out_ready);
  assign fin        = (idx_r == q_data.last_idx);
  assign q_pop      = load && fin;
  assign count_inc  = (&count_r) ? count_r : count_r + 1'b1;
  assign count_wide = 64'(count_inc);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.out_byte   = q_data.err ? 8'd0 : q_data.bytes[idx_r];
      out_data_nxt.run_end    = fin;
      out_data_nxt.stream_end = fin && q_data.last;
      out_data_nxt.error      = q_data.err;
      out_data_nxt.byte_total = q_data.err ? 32'd0 : count_wide[31:0];
      idx_nxt                 = fin ? IDX_ONE : idx_r + 1'b1;
      // Drop the count at stream end or on error.
      if (q_data.err || (fin && q_data.last)) begin
        count_nxt = '0;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      idx_r       <= IDX_ONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

### hw/rtl/utf16_to_utf8_stream_converter.sv
// Top level: UTF-16 code units in, UTF-8 bytes out, one byte per result.
// The first byte of an item passes through the queue and then the output register before it is presented.
// Throughput: one output byte per cycle while out_ready is high and the queue holds an item, set by
// the byte emitter; an item yields 1 to 4 bytes (3 for a non-surrogate unit above 0x7FF), a held lead surrogate none.
// A four-entry queue lets the input keep flowing while the output is stalled, until the queue fills.
// Reset (rst_n, synchronous, active low) empties the queue and clears surrogate and count.
module utf16_to_utf8_stream_converter #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  utf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output utf_pkg::out_t out_data
);
  import utf_pkg::*;

  logic   q_full, q_push, q_pop, q_valid;
  entry_t q_wdata, q_rdata;

  utf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  utf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  utf_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/utf_checker.sv
// Port-level checks for the converter, bound to the top level.
module utf_checker #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input utf_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input utf_pkg::out_t out_data
);
  import utf_pkg::*;

  localparam logic [31:0] TOTAL_MAX =
    (COUNT_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic out_acc;
  assign out_acc = out_valid && out_ready;

  // Hold a stalled result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Error result is a single zero byte that closes the stream.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |->
      out_data.run_end && out_data.stream_end &&
      out_data.out_byte == 8'd0 && out_data.byte_total == 32'd0)
    else $error("malformed error result");

  // Stream end always closes a run.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.run_end)
    else $error("stream end without run end");

  // Back-to-back bytes within a stream advance the count by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_data.stream_end && out_data.byte_total != TOTAL_MAX
      ##1 out_acc && !out_data.error |->
      out_data.byte_total == $past(out_data.byte_total) + 32'd1)
    else $error("byte count did not advance");

endmodule

bind utf16_to_utf8_stream_converter utf_checker #(
  .COUNT_WIDTH (COUNT_WIDTH)
) u_utf_checker (.*);
